@@ design/ddd_pkg.sv @@
// Shared types, constants and calendar functions for the date difference core.
package ddd_pkg;

   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned DAY_W   = 5;
   localparam int unsigned COUNT_W = 22;
   localparam int unsigned RES_W   = 9;   // year modulo 400
   localparam int unsigned QUOT_W  = 6;   // year / 400 for a 14-bit year
   localparam int unsigned PROD_W  = 2 * YEAR_W;
   localparam int unsigned RECIP_SHIFT = 22;

   // floor(y * RECIP_400 / 2**22) equals floor(y / 400) for every 14-bit year
   localparam logic [YEAR_W-1:0]  RECIP_400    = 14'd10486;
   localparam logic [YEAR_W-1:0]  YEARS_CYCLE  = 14'd400;
   localparam logic [RES_W-1:0]   RES_LAST     = 9'd399;
   localparam logic [MONTH_W-1:0] MONTH_JAN    = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC    = 4'd12;
   localparam logic [DAY_W-1:0]   DAY_FIRST    = 5'd1;
   localparam logic [COUNT_W-1:0] COUNT_MAX    = 22'h3FFFFF;

   // Controller to datapath commands
   typedef struct packed {
      logic load_in;    // capture the accepted word
      logic mul_end;    // feed the end year into the reciprocal multiplier
      logic res_start;  // take start year residue and start date check
      logic res_end;    // take end date check and error flag
      logic step;       // advance the walking date one day
      logic load_out;   // move the result into the output register
   } ddd_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic date_bad;   // either date fails the calendar check
      logic walk_more;  // walking date still before goal and count not saturated
   } ddd_stat_type;

   // Gregorian leap rule from the year residue modulo 400 and the two low year bits
   function automatic logic is_leap(input logic [RES_W-1:0] res,
                                    input logic [1:0] year_low);
      logic century;
      century = (res == 9'd100) || (res == 9'd200) || (res == 9'd300);
      return (res == '0) || (!century && (year_low == 2'b00));
   endfunction

   // Month length, zero for a month code outside 1 to 12
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      case (month) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         MONTH_FEB: len = leap ? 5'd29 : 5'd28;
         default: len = '0;
      endcase
      return len;
   endfunction

endpackage

@@ design/ddd_req_if.sv @@
// Request channel: two dates and the include-end flag.
interface ddd_req_if;
   logic                         valid;
   logic                         ready;
   logic [ddd_pkg::YEAR_W-1:0]   start_year;
   logic [ddd_pkg::MONTH_W-1:0]  start_month;
   logic [ddd_pkg::DAY_W-1:0]    start_day;
   logic [ddd_pkg::YEAR_W-1:0]   end_year;
   logic [ddd_pkg::MONTH_W-1:0]  end_month;
   logic [ddd_pkg::DAY_W-1:0]    end_day;
   logic                         include_end;

   modport source (output valid, output start_year, output start_month, output start_day,
                   output end_year, output end_month, output end_day, output include_end,
                   input ready);
   modport sink (input valid, input start_year, input start_month, input start_day,
                 input end_year, input end_month, input end_day, input include_end,
                 output ready);
endinterface

@@ design/ddd_rsp_if.sv @@
// Response channel: day count and date error flag.
interface ddd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ddd_pkg::COUNT_W-1:0]  day_count;
   logic                         date_error;

   modport source (output valid, output day_count, output date_error, input ready);
   modport sink (input valid, input day_count, input date_error, output ready);
endinterface

@@ design/ddd_ctrl.sv @@
// Controller: sequences date checks, the day walk and the output handoff.
module ddd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  ddd_pkg::ddd_stat_type stat,
   output ddd_pkg::ddd_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_MUL       = 3'd1;
   localparam logic [2:0] ST_RES_START = 3'd2;
   localparam logic [2:0] ST_RES_END   = 3'd3;
   localparam logic [2:0] ST_WALK      = 3'd4;
   localparam logic [2:0] ST_DONE      = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_RES_START;
         end
         ST_RES_START: begin
            cmd.res_start = 1'b1;
            cmd.mul_end   = 1'b1;
            state_in      = ST_RES_END;
         end
         ST_RES_END: begin
            cmd.res_end = 1'b1;
            state_in    = stat.date_bad ? ST_DONE : ST_WALK;
         end
         ST_WALK: begin
            if (stat.walk_more) begin
               cmd.step = 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold the response word until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ design/ddd_datapath.sv @@
// Datapath: date registers, modulo-400 unit, day walker and result register.
module ddd_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  ddd_pkg::ddd_cmd_type          cmd,
   output ddd_pkg::ddd_stat_type         stat,
   input  logic [ddd_pkg::YEAR_W-1:0]    in_start_year,
   input  logic [ddd_pkg::MONTH_W-1:0]   in_start_month,
   input  logic [ddd_pkg::DAY_W-1:0]     in_start_day,
   input  logic [ddd_pkg::YEAR_W-1:0]    in_end_year,
   input  logic [ddd_pkg::MONTH_W-1:0]   in_end_month,
   input  logic [ddd_pkg::DAY_W-1:0]     in_end_day,
   input  logic                          in_include_end,
   output logic [ddd_pkg::COUNT_W-1:0]   out_day_count,
   output logic                          out_date_error
);

   logic [ddd_pkg::YEAR_W-1:0]  walk_year_ff, walk_year_in;
   logic [ddd_pkg::MONTH_W-1:0] walk_month_ff, walk_month_in;
   logic [ddd_pkg::DAY_W-1:0]   walk_day_ff, walk_day_in;
   logic [ddd_pkg::RES_W-1:0]   walk_res_ff, walk_res_in;
   logic [ddd_pkg::YEAR_W-1:0]  goal_year_ff;
   logic [ddd_pkg::MONTH_W-1:0] goal_month_ff;
   logic [ddd_pkg::DAY_W-1:0]   goal_day_ff;
   logic [ddd_pkg::COUNT_W-1:0] step_count_ff, step_count_in;
   logic                        inc_ff;
   logic                        start_ok_ff;
   logic                        err_ff;
   logic [ddd_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [ddd_pkg::COUNT_W-1:0] out_count_ff, out_count_in;
   logic                        out_err_ff;

   logic [ddd_pkg::YEAR_W-1:0]  mul_year;
   logic [ddd_pkg::QUOT_W-1:0]  quot;
   logic [ddd_pkg::YEAR_W-1:0]  res_year;
   logic [ddd_pkg::YEAR_W-1:0]  res_full;
   logic [ddd_pkg::RES_W-1:0]   res;
   logic                        res_leap;
   logic                        start_ok, end_ok;
   logic [ddd_pkg::DAY_W-1:0]   walk_len;
   logic                        walk_before;
   logic [ddd_pkg::COUNT_W-1:0] final_count;

   // Reciprocal multiply for year / 400, registered before use
   assign mul_year = cmd.mul_end ? goal_year_ff : walk_year_ff;
   assign prod_in  = {{ddd_pkg::YEAR_W{1'b0}}, mul_year}
                   * {{ddd_pkg::YEAR_W{1'b0}}, ddd_pkg::RECIP_400};

   // Residue of the year modulo 400 and calendar checks
   assign quot     = prod_ff[ddd_pkg::RECIP_SHIFT +: ddd_pkg::QUOT_W];
   assign res_year = cmd.res_end ? goal_year_ff : walk_year_ff;
   assign res_full = res_year - ({{(ddd_pkg::YEAR_W-ddd_pkg::QUOT_W){1'b0}}, quot}
                               * ddd_pkg::YEARS_CYCLE);
   assign res      = res_full[ddd_pkg::RES_W-1:0];
   assign res_leap = ddd_pkg::is_leap(res, res_year[1:0]);
   assign start_ok = (walk_day_ff >= ddd_pkg::DAY_FIRST)
                  && (walk_day_ff <= ddd_pkg::month_days(walk_month_ff, res_leap));
   assign end_ok   = (goal_day_ff >= ddd_pkg::DAY_FIRST)
                  && (goal_day_ff <= ddd_pkg::month_days(goal_month_ff, res_leap));

   // Walk compare and saturation
   assign walk_before = {walk_year_ff, walk_month_ff, walk_day_ff}
                      < {goal_year_ff, goal_month_ff, goal_day_ff};
   assign stat.walk_more = walk_before && (step_count_ff != ddd_pkg::COUNT_MAX);
   assign stat.date_bad  = !(start_ok_ff && end_ok);

   // Load the walking date, take its residue, or advance it by one day
   assign walk_len = ddd_pkg::month_days(walk_month_ff,
                                         ddd_pkg::is_leap(walk_res_ff, walk_year_ff[1:0]));
   always_comb begin
      walk_year_in  = walk_year_ff;
      walk_month_in = walk_month_ff;
      walk_day_in   = walk_day_ff;
      walk_res_in   = walk_res_ff;
      step_count_in = step_count_ff;
      if (cmd.load_in) begin
         walk_year_in  = in_start_year;
         walk_month_in = in_start_month;
         walk_day_in   = in_start_day;
         step_count_in = '0;
      end else if (cmd.res_start) begin
         walk_res_in = res;
      end else if (cmd.step) begin
         step_count_in = step_count_ff + 1'b1;
         if (walk_day_ff < walk_len) begin
            walk_day_in = walk_day_ff + 1'b1;
         end else begin
            walk_day_in = ddd_pkg::DAY_FIRST;
            if (walk_month_ff == ddd_pkg::MONTH_DEC) begin
               walk_month_in = ddd_pkg::MONTH_JAN;
               walk_year_in  = walk_year_ff + 1'b1;
               walk_res_in   = (walk_res_ff == ddd_pkg::RES_LAST) ? '0 : walk_res_ff + 1'b1;
            end else begin
               walk_month_in = walk_month_ff + 1'b1;
            end
         end
      end
   end

   // Saturating final count, zero on a bad date
   always_comb begin
      if (err_ff) begin
         final_count = '0;
      end else if (step_count_ff == ddd_pkg::COUNT_MAX) begin
         final_count = ddd_pkg::COUNT_MAX;
      end else begin
         final_count = step_count_ff + {{(ddd_pkg::COUNT_W-1){1'b0}}, inc_ff};
      end
   end
   assign out_count_in = cmd.load_out ? final_count : out_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_year_ff  <= '0;
         walk_month_ff <= '0;
         walk_day_ff   <= '0;
         walk_res_ff   <= '0;
         goal_year_ff  <= '0;
         goal_month_ff <= '0;
         goal_day_ff   <= '0;
         step_count_ff <= '0;
         inc_ff        <= 1'b0;
         start_ok_ff   <= 1'b0;
         err_ff        <= 1'b0;
      end else begin
         walk_year_ff  <= walk_year_in;
         walk_month_ff <= walk_month_in;
         walk_day_ff   <= walk_day_in;
         walk_res_ff   <= walk_res_in;
         step_count_ff <= step_count_in;
         if (cmd.load_in) begin
            goal_year_ff  <= in_end_year;
            goal_month_ff <= in_end_month;
            goal_day_ff   <= in_end_day;
            inc_ff        <= in_include_end;
         end
         if (cmd.res_start) begin
            start_ok_ff <= start_ok;
         end
         if (cmd.res_end) begin
            err_ff <= stat.date_bad;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      prod_ff      <= prod_in;
      out_count_ff <= out_count_in;
      if (cmd.load_out) begin
         out_err_ff <= err_ff;
      end
   end

   assign out_day_count  = out_count_ff;
   assign out_date_error = out_err_ff;

endmodule

@@ design/date_difference_in_days_core.sv @@
// Top level of the Gregorian date difference core.
//
// A request word carries a start date, an end date (year, month, day) and
// include_end. The response word carries day_count and date_error.
// Both dates are checked against the Gregorian calendar; if either fails,
// date_error is set and day_count is 0. Otherwise the start date is walked
// forward one day per clock until it reaches the end date, and day_count is
// the number of days walked, plus one when include_end is set, saturating
// at 4194303. A start on or after the end gives 0, or 1 with include_end.
// The time from request accept to response valid grows with N, the number
// of days walked (at most 4194303), as the day walker advances one calendar
// day per cycle. A bad date skips the walk.
// One request is in flight at a time: req ready is high only while idle,
// so a new request waits until the previous result is in the output register.
// The response sits in an output register; a stall on the response side
// holds it, and the next request can be accepted and worked meanwhile,
// finishing into the output register once the old word is taken.
// Synchronous reset returns the core to idle with no response pending.
module date_difference_in_days_core (
   input  logic       clock,
   input  logic       reset,
   ddd_req_if.sink    req_bus,
   ddd_rsp_if.source  rsp_bus
);

   ddd_pkg::ddd_cmd_type  cmd;
   ddd_pkg::ddd_stat_type stat;

   ddd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ddd_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .in_start_year  (req_bus.start_year),
      .in_start_month (req_bus.start_month),
      .in_start_day   (req_bus.start_day),
      .in_end_year    (req_bus.end_year),
      .in_end_month   (req_bus.end_month),
      .in_end_day     (req_bus.end_day),
      .in_include_end (req_bus.include_end),
      .out_day_count  (rsp_bus.day_count),
      .out_date_error (rsp_bus.date_error)
   );

endmodule
